/* src/lattice_coeff_compress_pack_defines.svh */
// Assertion helpers shared by the RTL.
`ifndef LATTICE_COEFF_COMPRESS_PACK_DEFINES_SVH
`define LATTICE_COEFF_COMPRESS_PACK_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define LCCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lccp assertion failed");

// Next-cycle implication, gated by reset.
`define LCCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lccp assertion failed");

`endif

/* src/lccp_pkg.sv */
`default_nettype none

package lccp_pkg;

    localparam int DATA_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 10;
    localparam int NUM_W   = 27;
    localparam int RECIP_SHIFT = 27;
    localparam int PEND_W  = 9;
    localparam int CNT_W   = 4;
    localparam int CFG_W   = 4;

    localparam logic [3:0] CODE_BITS_NARROW = 4'd9;
    localparam logic [3:0] CODE_BITS_RESET  = 4'd10;

    localparam logic [NUM_W-1:0] HALF_9  = NUM_W'(256);
    localparam logic [NUM_W-1:0] HALF_10 = NUM_W'(512);

    typedef enum logic [0:0] {
        REG_DIRECTION = 1'b0,
        REG_CODE_BITS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic ld_in;
        logic ld_mul;
        logic ld_fix;
    } quant_ctl_t;

endpackage

`default_nettype wire

/* src/lccp_quant.sv */
`default_nettype none

module lccp_quant #(
    parameter int MODULUS = 7681
) (
    input  wire                                clk,
    input  wire lccp_pkg::quant_ctl_t          ctl,
    input  wire                                wide_code,
    input  wire [lccp_pkg::DATA_W-1:0]         data_in,
    output logic [lccp_pkg::CODE_W-1:0]        code,
    output logic [lccp_pkg::BYTE_W-1:0]        byte_out
);

    localparam int NUM_W   = lccp_pkg::NUM_W;
    localparam int RECIP   = (1 << lccp_pkg::RECIP_SHIFT) / MODULUS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int HALF    = MODULUS / 2;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int BACK_W  = RECIP_W + lccp_pkg::DATA_W;

    logic [lccp_pkg::DATA_W-1:0] x_reg;
    logic [NUM_W-1:0]            num;
    logic [PROD_W-1:0]           prod;
    logic [NUM_W-1:0]            num_reg;
    logic [RECIP_W-1:0]          qest_reg;
    logic [lccp_pkg::BYTE_W-1:0] byte_mid_reg;
    logic [BACK_W-1:0]           back;
    logic [NUM_W-1:0]            rem;
    logic                        corr;
    logic [lccp_pkg::CODE_W-1:0] qq;
    logic [lccp_pkg::CODE_W-1:0] code_next;
    logic [lccp_pkg::CODE_W-1:0] code_reg;
    logic [lccp_pkg::BYTE_W-1:0] byte_reg;

    always_comb
    begin
        if (wide_code)
        begin
            num = {1'b0, x_reg, 10'b0} + NUM_W'(HALF);
        end
        else
        begin
            num = {2'b0, x_reg, 9'b0} + NUM_W'(HALF);
        end
        prod = {{RECIP_W{1'b0}}, num} * {{NUM_W{1'b0}}, RECIP_W'(RECIP)};
    end

    always_comb
    begin
        back = {{lccp_pkg::DATA_W{1'b0}}, qest_reg}
             * {{RECIP_W{1'b0}}, lccp_pkg::DATA_W'(MODULUS)};
        rem  = num_reg - back[NUM_W-1:0];
        corr = (rem >= NUM_W'(MODULUS));
        qq   = qest_reg[lccp_pkg::CODE_W-1:0] + {{(lccp_pkg::CODE_W-1){1'b0}}, corr};
        if (wide_code)
        begin
            code_next = qq;
        end
        else
        begin
            code_next = {1'b0, qq[lccp_pkg::CODE_W-2:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_in)
        begin
            x_reg <= data_in;
        end
        if (ctl.ld_mul)
        begin
            num_reg      <= num;
            qest_reg     <= prod[PROD_W-1:lccp_pkg::RECIP_SHIFT];
            byte_mid_reg <= x_reg[lccp_pkg::BYTE_W-1:0];
        end
        if (ctl.ld_fix)
        begin
            code_reg <= code_next;
            byte_reg <= byte_mid_reg;
        end
    end

    assign code     = code_reg;
    assign byte_out = byte_reg;

endmodule

`default_nettype wire

/* src/lattice_coeff_compress_pack.sv */
// Streams coefficients into packed d-bit codes (direction 0) or packed bytes back into
// coefficients (direction 1), d being 9 or 10, over a fixed modulus. Five register
// stages sit between s_tdata and m_tdata: input, reciprocal multiply, remainder
// correction, a result queue of up to three entries filled by bit packing against the
// accumulator, and the output register, where decompressed codes are scaled back.
// The packing stage takes one item per cycle while the result queue has room; the output
// register passes one result per cycle unless m_tready is low. A decompressed byte yields
// at most one code, a coefficient one or two bytes (d/8 on average) plus any flush byte.
`default_nettype none

`include "lattice_coeff_compress_pack_defines.svh"

module lattice_coeff_compress_pack #(
    parameter int MODULUS = 7681
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_wr_en,
    input  wire                               cfg_index,
    input  wire [lccp_pkg::CFG_W-1:0]         cfg_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [lccp_pkg::DATA_W-1:0]        s_tdata,   // data_in
    input  wire                               s_tlast,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [lccp_pkg::DATA_W-1:0]       m_tdata,   // data_out
    output logic                              m_tlast
);

    localparam int PEND_W = lccp_pkg::PEND_W;
    localparam int CNT_W  = lccp_pkg::CNT_W;
    localparam int CODE_W = lccp_pkg::CODE_W;
    localparam int BYTE_W = lccp_pkg::BYTE_W;
    localparam int NUM_W  = lccp_pkg::NUM_W;

    logic                     dir_reg;
    logic [3:0]               code_bits_reg;
    logic                     wide_code;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                     s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic                     s1_free, s2_free, s3_free, s4_free;
    logic                     s3_go, accept;
    lccp_pkg::quant_ctl_t     qctl;
    logic [CODE_W-1:0]        s3_code;
    logic [BYTE_W-1:0]        s3_byte;

    logic [PEND_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [4:0]               d_w;

    logic [23:0]              wide_c;
    logic [4:0]               total_c, rem_c;
    logic [1:0]               nfull;
    logic [23:0]              rest_c;
    logic [16:0]              wide_d, rest_d;
    logic [4:0]               total_d, cnt_d;
    logic                     have_d;

    logic [1:0]               grp_n;
    logic [CODE_W-1:0]        grp_ent [3];

    logic [CODE_W-1:0]        s4_ent_reg [3];
    logic [1:0]               s4_n_reg, s4_idx_reg;
    logic                     s4_final, out_take, out_load, s4_done;
    logic [CODE_W-1:0]        cur_ent;
    logic [NUM_W-1:0]         rec;
    logic [lccp_pkg::DATA_W-1:0] out_value;

    logic                     out_valid_reg, out_last_reg;
    logic [lccp_pkg::DATA_W-1:0] out_data_reg;

    assign wide_code = (code_bits_reg != lccp_pkg::CODE_BITS_NARROW);
    assign d_w       = wide_code ? 5'd10 : 5'd9;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= 1'b0;
            code_bits_reg <= lccp_pkg::CODE_BITS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (lccp_pkg::reg_index_t'(cfg_index))
                lccp_pkg::REG_DIRECTION: dir_reg       <= cfg_data[0];
                lccp_pkg::REG_CODE_BITS: code_bits_reg <= cfg_data;
                default:                 dir_reg       <= dir_reg;
            endcase
        end
    end

    // pipeline flow control
    assign out_take = !out_valid_reg || m_tready;
    assign out_load = s4_valid_reg && out_take;
    assign s4_final = (s4_idx_reg == s4_n_reg - 2'd1);
    assign s4_done  = out_load && s4_final;
    assign s4_free  = !s4_valid_reg || s4_done;
    assign s3_go    = s3_valid_reg && ((grp_n == 2'd0) || s4_free);
    assign s3_free  = !s3_valid_reg || s3_go;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s1_free;

    assign qctl.ld_in  = accept;
    assign qctl.ld_mul = s2_free && s1_valid_reg;
    assign qctl.ld_fix = s3_free && s2_valid_reg;

    lccp_quant #(
        .MODULUS (MODULUS)
    ) u_quant (
        .clk       (clk),
        .ctl       (qctl),
        .wide_code (wide_code),
        .data_in   (s_tdata),
        .code      (s3_code),
        .byte_out  (s3_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= s_tlast;
        end
        if (qctl.ld_mul)
        begin
            s2_last_reg <= s1_last_reg;
        end
        if (qctl.ld_fix)
        begin
            s3_last_reg <= s2_last_reg;
        end
    end

    // packing against the bit accumulator
    always_comb
    begin
        wide_c  = {{(24-PEND_W){1'b0}}, acc_reg}
                | ({{(24-CODE_W){1'b0}}, s3_code} << cnt_reg);
        total_c = {1'b0, cnt_reg} + d_w;
        if (total_c >= 5'd16)
        begin
            nfull = 2'd2;
        end
        else if (total_c >= 5'd8)
        begin
            nfull = 2'd1;
        end
        else
        begin
            nfull = 2'd0;
        end
        rem_c  = total_c - {nfull, 3'b000};
        rest_c = wide_c >> {nfull, 3'b000};

        wide_d  = {{(17-PEND_W){1'b0}}, acc_reg}
                | ({{(17-BYTE_W){1'b0}}, s3_byte} << cnt_reg);
        total_d = {1'b0, cnt_reg} + 5'd8;
        have_d  = (total_d >= d_w);
        rest_d  = have_d ? (wide_d >> d_w) : wide_d;
        cnt_d   = have_d ? (total_d - d_w) : total_d;

        if (!dir_reg)
        begin
            grp_n      = nfull + {1'b0, (s3_last_reg && (rem_c != 5'd0))};
            grp_ent[0] = {2'b00, wide_c[7:0]};
            grp_ent[1] = {2'b00, wide_c[15:8]};
            grp_ent[2] = {2'b00, wide_c[23:16]};
            acc_next   = rest_c[PEND_W-1:0];
            cnt_next   = rem_c[CNT_W-1:0];
        end
        else
        begin
            grp_n      = {1'b0, have_d};
            grp_ent[0] = wide_code ? wide_d[9:0] : {1'b0, wide_d[8:0]};
            grp_ent[1] = '0;
            grp_ent[2] = '0;
            acc_next   = rest_d[PEND_W-1:0];
            cnt_next   = cnt_d[CNT_W-1:0];
        end
        if (s3_last_reg)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (s3_go)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // result queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s4_idx_reg   <= '0;
        end
        else if (s4_free)
        begin
            s4_valid_reg <= s3_go && (grp_n != 2'd0);
            s4_idx_reg   <= '0;
        end
        else if (out_load)
        begin
            s4_idx_reg <= s4_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_free && s3_go)
        begin
            s4_ent_reg <= grp_ent;
            s4_n_reg   <= grp_n;
            s4_last_reg <= s3_last_reg;
        end
    end

    // scale decompressed codes on the way out
    always_comb
    begin
        cur_ent = s4_ent_reg[s4_idx_reg];
        rec     = {{(NUM_W-CODE_W){1'b0}}, cur_ent} * NUM_W'(MODULUS)
                + (wide_code ? lccp_pkg::HALF_10 : lccp_pkg::HALF_9);
        if (!dir_reg)
        begin
            out_value = {{(lccp_pkg::DATA_W-BYTE_W){1'b0}}, cur_ent[BYTE_W-1:0]};
        end
        else if (wide_code)
        begin
            out_value = rec[25:10];
        end
        else
        begin
            out_value = rec[24:9];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_value;
            out_last_reg <= s4_last_reg && s4_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `LCCP_ASSERT_NOW(a_pending_clean, clk, rst_n, 1'b1, ((cnt_reg <= 4'd9) && ((acc_reg >> cnt_reg) == '0)))
    `LCCP_ASSERT_NOW(a_queue_index, clk, rst_n, s4_valid_reg, ((s4_idx_reg < s4_n_reg) && (s4_n_reg != 2'd0)))
    `LCCP_ASSERT_NOW(a_queue_room, clk, rst_n, (s3_go && (grp_n != 2'd0)), s4_free)
    `LCCP_ASSERT_NEXT(a_flush_clears, clk, rst_n, (s3_go && s3_last_reg), ((cnt_reg == '0) && (acc_reg == '0)))

endmodule

`default_nettype wire

/* verif/lccp_codec_checker.sv */
module lccp_codec_checker
    import lccp_pkg::*;
#(
    parameter int MODULUS = 7681
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_wr_en,
    input  wire                cfg_index,
    input  wire [CFG_W-1:0]    cfg_data,
    input  wire                s_tvalid,
    input  wire                s_tready,
    input  wire [DATA_W-1:0]   s_tdata,   // data_in
    input  wire                s_tlast,
    input  wire                m_tvalid,
    input  wire                m_tready,
    input  wire [DATA_W-1:0]   m_tdata,   // data_out
    input  wire                m_tlast,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
    } codec_word_t;

    codec_word_t expected_words[$];

    logic              mode_decomp;
    logic [CFG_W-1:0]  width_reg;
    logic [16:0]       pend_bits;
    logic [4:0]        pend_count;

    // Predict the words one request produces and advance the bit accumulator.
    task automatic predict_codec_step(input logic [DATA_W-1:0] x, input logic last);
        codec_word_t words[4];
        logic [31:0] acc;
        logic [31:0] mask;
        logic [31:0] code;
        logic [31:0] v;
        int unsigned d;
        int unsigned cnt;
        int n;
        d = (width_reg == CODE_BITS_NARROW) ? 9 : 10;
        mask = (32'd1 << d) - 32'd1;
        cnt = pend_count;
        if (cnt > 17)
            cnt = 17;
        acc = {15'd0, pend_bits};
        if (cnt < 17)
            acc &= (32'd1 << cnt) - 32'd1;
        n = 0;
        if (!mode_decomp)
        begin
            code = ((({16'd0, x}) << d) + 32'(MODULUS / 2)) / 32'(MODULUS);
            code &= mask;
            acc |= code << cnt;
            cnt += d;
            while (cnt >= 8)
            begin
                words[n] = '{data: {8'd0, acc[7:0]}, last: 1'b0};
                n++;
                acc >>= 8;
                cnt -= 8;
            end
            if (last)
            begin
                if (cnt > 0)
                begin
                    words[n] = '{data: {8'd0, acc[7:0]}, last: 1'b0};
                    n++;
                end
                acc = '0;
                cnt = 0;
            end
        end
        else
        begin
            acc |= {24'd0, x[7:0]} << cnt;
            cnt += 8;
            while (cnt >= d)
            begin
                v = acc & mask;
                code = (v * 32'(MODULUS) + (32'd1 << (d - 1))) >> d;
                words[n] = '{data: code[DATA_W-1:0], last: 1'b0};
                n++;
                acc >>= d;
                cnt -= d;
            end
            if (last)
            begin
                acc = '0;
                cnt = 0;
            end
        end
        if (last && n > 0)
            words[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_words.push_back(words[i]);
        pend_bits = acc[16:0];
        pend_count = cnt[4:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        codec_word_t w;
        if (!rst_n)
        begin
            mode_decomp = 1'b0;
            width_reg = CODE_BITS_RESET;
            pend_bits = '0;
            pend_count = '0;
            expected_words.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_DIRECTION)
                    mode_decomp = cfg_data[0];
                else
                    width_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_codec_step(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result: data_out %0h last_out %0b", m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (m_tdata !== w.data)
                    begin
                        $error("data_out: expected %0h, actual %0h", w.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== w.last)
                    begin
                        $error("last_out: expected %0b, actual %0b", w.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_words.size();
        end
    end

endmodule

/* verif/lattice_coeff_compress_pack_tb.sv */
module lattice_coeff_compress_pack_tb;

    import lccp_pkg::*;

    localparam int MOD_Q        = 7681;
    localparam int SETTLE_CYC   = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 57;
    localparam int HOLD_CYC     = 300;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata;   // data_in
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [DATA_W-1:0]  m_tdata;   // data_out
    logic               m_tlast;

    int fail_count;
    int pending_count;
    bit rx_hold_req;
    bit burst_mode;

    lattice_coeff_compress_pack #(
        .MODULUS(MOD_Q)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    lccp_codec_checker #(
        .MODULUS(MOD_Q)
    ) codec_chk (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_coeff();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return DATA_W'($urandom_range(0, MOD_Q - 1));
        if (r < 95)
            return DATA_W'($urandom);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return DATA_W'(MOD_Q - 1);
            2: return DATA_W'(MOD_Q);
            default: return '1;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_byte();
        if ($urandom_range(0, 99) < 70)
            return {8'd0, 8'($urandom)};
        return DATA_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 5))
            0, 1: return CODE_BITS_NARROW;
            2, 3: return CODE_BITS_RESET;
            4: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [DATA_W-1:0] x, input logic last);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drain all outstanding words, let the pipeline settle, then write.
    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
            end
            else
            begin
                int stall;
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int sent;
        int len;
        int k;
        int guard;
        bit close;
        logic dir;
        logic [CFG_W-1:0] width;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_DIRECTION;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        rx_hold_req = 1'b0;
        burst_mode = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_DIRECTION, 4'd0);
        write_reg(REG_CODE_BITS, CODE_BITS_RESET);
        send_item(16'd0, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(DATA_W'(MOD_Q - 1), 1'b0);
        send_item(DATA_W'(MOD_Q), 1'b0);
        send_item(16'hffff, 1'b0);
        send_item(16'd3840, 1'b1);

        write_reg(REG_CODE_BITS, CODE_BITS_NARROW);
        send_item(16'd0, 1'b0);
        send_item(16'hffff, 1'b0);
        send_item(16'd1234, 1'b0);
        send_item(16'd5000, 1'b1);
        // leave bits pending across the width and mode changes
        send_item(16'd2222, 1'b0);

        write_reg(REG_CODE_BITS, 4'hf);
        send_item(16'd7000, 1'b0);
        write_reg(REG_DIRECTION, 4'd1);
        send_item(16'hffa5, 1'b0);
        send_item(16'h00ff, 1'b0);
        send_item(16'h1234, 1'b1);
        send_item(16'h0080, 1'b1);

        write_reg(REG_CODE_BITS, 4'd0);
        send_item(16'h00ff, 1'b0);
        send_item(16'hff00, 1'b0);
        send_item(16'h00ff, 1'b1);
        write_reg(REG_CODE_BITS, CODE_BITS_NARROW);
        send_item(16'h005a, 1'b0);
        send_item(16'h00c3, 1'b1);
        write_reg(REG_DIRECTION, 4'd0);
        send_item(16'd100, 1'b1);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            dir = ($urandom_range(0, 1) != 0);
            width = pick_width();
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_DIRECTION, {3'd0, dir});
                write_reg(REG_CODE_BITS, width);
            end
            else
            begin
                write_reg(REG_CODE_BITS, width);
                write_reg(REG_DIRECTION, {3'd0, dir});
            end
            burst_mode = ($urandom_range(0, 3) == 0) && ph != 2;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                  : $urandom_range(1, 24);
                if (len > PHASE_ITEMS - sent)
                    len = PHASE_ITEMS - sent;
                close = ($urandom_range(0, 99) < 85);
                for (k = 0; k < len; k++)
                begin
                    send_item(dir ? pick_byte() : pick_coeff(), close && k == len - 1);
                    sent++;
                    if (ph == 2 && sent == 10)
                        rx_hold_req = 1'b1;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (pending_count != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYC) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
